### rtl/uer_pkg.sv
// shared types and constants of the ultrasonic echo ranger
package uer_pkg;

  localparam int unsigned EN_W    = 1;
  localparam int unsigned TRIG_W  = 10;
  localparam int unsigned TMO_W   = 20;
  localparam int unsigned COEF_W  = 24;
  localparam int unsigned DIST_W  = 22;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned FRAC_SH = 16;

  localparam logic [TRIG_W-1:0] TRIG_RST = 10'd100;
  localparam logic [TMO_W-1:0]  TMO_RST  = 20'd500000;
  localparam logic [COEF_W-1:0] COEF_RST = 24'd285456;
  localparam logic [DIST_W-1:0] DIST_MAX = 22'h3FFFFF;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_RISE = 4'b0100,
    PH_MEAS = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOECHO   = 2'd1,
    ST_LONG     = 2'd2,
    ST_DISABLED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_ENABLED = 2'd0,
    CFG_TRIGGER = 2'd1,
    CFG_TIMEOUT = 2'd2,
    CFG_COEF    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              load;
    logic              step;
  } dist_cmd_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance_q8;
    status_t           status;
    logic              done_res;
    logic              trigger_out;
  } res_t;

endpackage

### rtl/uer_dist.sv
// running product of echo ticks and scale coefficient, with saturating readout
module uer_dist #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                           clk,
  input  uer_pkg::dist_cmd_t             cmd,
  input  logic [uer_pkg::COEF_W-1:0]     scale_coef,
  output logic [uer_pkg::DIST_W-1:0]     distance_q8
);

  localparam int unsigned AW = COUNT_BITS + uer_pkg::COEF_W;

  logic [AW-1:0] acc_r;
  logic [AW-1:0] acc_nxt;
  logic [AW-1:0] acc_sh;

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.load) begin
      acc_nxt = AW'(scale_coef);
    end else if (cmd.step) begin
      acc_nxt = acc_r + AW'(scale_coef);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc_sh = acc_r >> uer_pkg::FRAC_SH;

  always_comb begin
    if (acc_sh > AW'(uer_pkg::DIST_MAX)) begin
      distance_q8 = uer_pkg::DIST_MAX;
    end else begin
      distance_q8 = uer_pkg::DIST_W'(acc_sh);
    end
  end

endmodule

### rtl/uer_fsm.sv
// trigger, echo wait and echo timing sequencer with tick counter
module uer_fsm #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic                           start_req,
  input  logic                           echo_level,
  input  logic                           enabled,
  input  logic [uer_pkg::TRIG_W-1:0]     trigger_ticks,
  input  logic [uer_pkg::TMO_W-1:0]      timeout_ticks,
  input  logic [uer_pkg::DIST_W-1:0]     dist_in,
  output uer_pkg::dist_cmd_t             cmd,
  output uer_pkg::res_t                  res
);

  localparam int unsigned CW   = COUNT_BITS;
  localparam int unsigned CMPW = (CW > uer_pkg::TMO_W) ? CW : uer_pkg::TMO_W;
  localparam logic [CW-1:0] CntMax = {CW{1'b1}};

  uer_pkg::phase_t phase_r, phase_nxt;
  logic [CW-1:0]   tc_r, tc_nxt;
  logic [CW-1:0]   tc_up;
  logic            up_limit;
  logic            trig_end;

  assign tc_up    = (tc_r == CntMax) ? CntMax : tc_r + CW'(1);
  assign up_limit = (CMPW'(tc_up) >= CMPW'(timeout_ticks)) || (tc_up == CntMax);
  assign trig_end = (tc_up >= CW'(trigger_ticks)) || (tc_up == CntMax);

  always_comb begin
    phase_nxt = phase_r;
    tc_nxt    = tc_r;
    cmd       = '0;
    res       = '0;
    res.status = uer_pkg::ST_OK;
    unique case (phase_r)
      uer_pkg::PH_IDLE: begin
        if (start_req) begin
          if (!enabled) begin
            res.done_res = 1'b1;
            res.status   = uer_pkg::ST_DISABLED;
          end else begin
            res.trigger_out = 1'b1;
            if (trigger_ticks <= uer_pkg::TRIG_W'(1)) begin
              phase_nxt = uer_pkg::PH_RISE;
              tc_nxt    = '0;
            end else begin
              phase_nxt = uer_pkg::PH_TRIG;
              tc_nxt    = CW'(1);
            end
          end
        end
      end
      uer_pkg::PH_TRIG: begin
        res.trigger_out = 1'b1;
        if (trig_end) begin
          phase_nxt = uer_pkg::PH_RISE;
          tc_nxt    = '0;
        end else begin
          tc_nxt = tc_up;
        end
      end
      uer_pkg::PH_RISE: begin
        if (echo_level) begin
          if (timeout_ticks <= uer_pkg::TMO_W'(1)) begin
            phase_nxt    = uer_pkg::PH_IDLE;
            tc_nxt       = '0;
            res.done_res = 1'b1;
            res.status   = uer_pkg::ST_LONG;
          end else begin
            phase_nxt = uer_pkg::PH_MEAS;
            tc_nxt    = CW'(1);
            cmd.load  = 1'b1;
          end
        end else if (up_limit) begin
          phase_nxt    = uer_pkg::PH_IDLE;
          tc_nxt       = '0;
          res.done_res = 1'b1;
          res.status   = uer_pkg::ST_NOECHO;
        end else begin
          tc_nxt = tc_up;
        end
      end
      uer_pkg::PH_MEAS: begin
        if (!echo_level) begin
          phase_nxt       = uer_pkg::PH_IDLE;
          tc_nxt          = '0;
          res.done_res    = 1'b1;
          res.distance_q8 = dist_in;
        end else if (up_limit) begin
          phase_nxt    = uer_pkg::PH_IDLE;
          tc_nxt       = '0;
          res.done_res = 1'b1;
          res.status   = uer_pkg::ST_LONG;
        end else begin
          tc_nxt   = tc_up;
          cmd.step = 1'b1;
        end
      end
      default: begin
        phase_nxt = uer_pkg::PH_IDLE;
        tc_nxt    = '0;
      end
    endcase
    if (!step) begin
      cmd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= uer_pkg::PH_IDLE;
      tc_r    <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      tc_r    <= tc_nxt;
    end
  end

endmodule

### rtl/ultrasonic_echo_ranger.sv
// ultrasonic echo ranger top level: config registers, input and result registers
//
// usage:
//   in_ stream carries one word per microsecond tick: start request and the
//   sampled echo pin. out_ stream returns exactly one word per input word:
//   trigger pin level, done flag, status and distance in cm (8 fraction bits).
//   cfg_ port writes enabled, trigger length, timeout and scale coefficient;
//   write it only while no measurement is running.
// path: an accepted word waits in the input register, then its result moves into
//   the result register once that register is free or being taken.
// throughput: one word per cycle while out_tready stays high; the result
//   register and the input register form a two-stage pipe, so a new word is
//   accepted while a finished result waits to be taken.
// distance is a running sum of the coefficient kept per echo tick, so the
//   final value needs only a shift and a saturating compare.
// reset: sequencer returns to idle, tick counter clears, registers take their
//   default values (disabled, 100, 500000, 285456), both pipe stages empty.
// stall: when out_tready is low the result register holds, the input
//   register fills and in_tready drops until the result is taken.
module ultrasonic_echo_ranger #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // start_req, echo_level
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // trigger_out, done_res, status[1:0], distance_q8[21:0]
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);

  logic                          en_r;
  logic [uer_pkg::TRIG_W-1:0]    trig_ticks_r;
  logic [uer_pkg::TMO_W-1:0]     tmo_ticks_r;
  logic [uer_pkg::COEF_W-1:0]    coef_r;

  logic                          s_valid_r;
  logic                          s_start_r;
  logic                          s_echo_r;
  logic                          out_valid_r;
  uer_pkg::res_t                 out_res_r;

  logic                          process;
  uer_pkg::dist_cmd_t            dist_cmd;
  uer_pkg::res_t                 res;
  logic [uer_pkg::DIST_W-1:0]    dist_q8;

  assign process   = s_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s_valid_r || process;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r         <= 1'b0;
      trig_ticks_r <= uer_pkg::TRIG_RST;
      tmo_ticks_r  <= uer_pkg::TMO_RST;
      coef_r       <= uer_pkg::COEF_RST;
    end else if (cfg_wr_en) begin
      unique case (uer_pkg::cfg_idx_t'(cfg_addr))
        uer_pkg::CFG_ENABLED: en_r         <= cfg_wdata[0];
        uer_pkg::CFG_TRIGGER: trig_ticks_r <= cfg_wdata[uer_pkg::TRIG_W-1:0];
        uer_pkg::CFG_TIMEOUT: tmo_ticks_r  <= cfg_wdata[uer_pkg::TMO_W-1:0];
        uer_pkg::CFG_COEF:    coef_r       <= cfg_wdata[uer_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_tready) begin
      s_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s_start_r <= in_tdata[0];
      s_echo_r  <= in_tdata[1];
    end
  end

  uer_fsm #(
    .COUNT_BITS (COUNT_BITS)
  ) u_fsm (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (process),
    .start_req     (s_start_r),
    .echo_level    (s_echo_r),
    .enabled       (en_r),
    .trigger_ticks (trig_ticks_r),
    .timeout_ticks (tmo_ticks_r),
    .dist_in       (dist_q8),
    .cmd           (dist_cmd),
    .res           (res)
  );

  uer_dist #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dist (
    .clk         (clk),
    .cmd         (dist_cmd),
    .scale_coef  (coef_r),
    .distance_q8 (dist_q8)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (process) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_res_r.distance_q8, out_res_r.status,
                       out_res_r.done_res, out_res_r.trigger_out};

`ifndef SYNTH
  a_dist_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.status != uer_pkg::ST_OK) |-> out_res_r.distance_q8 == '0)
    else $error("distance reported with non-ok status");

  a_trig_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.trigger_out && out_res_r.done_res))
    else $error("trigger high on a finishing word");

  a_ready_low_only_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without output backpressure");
`endif

endmodule

### tb/testbench.sv
// self-checking stream testbench for the ultrasonic echo ranger: tick stimulus, result check
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CNT_W      = 20;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned RAND_WORDS = 1000;
  localparam int unsigned TAIL_WORDS = 150;
  localparam int unsigned HOLD_AT    = 400;
  localparam int unsigned HOLD_LEN   = 80;

  class range_scoreboard;
    logic                       enabled;
    logic [uer_pkg::TRIG_W-1:0] trig_len;
    logic [uer_pkg::TMO_W-1:0]  timeout;
    logic [uer_pkg::COEF_W-1:0] coef;
    uer_pkg::phase_t            phase;
    logic [CNT_W-1:0]           ticks;
    uer_pkg::res_t              pending_results[$];
    int                         errors;

    function new();
      enabled  = 1'b0;
      trig_len = uer_pkg::TRIG_RST;
      timeout  = uer_pkg::TMO_RST;
      coef     = uer_pkg::COEF_RST;
      phase    = uer_pkg::PH_IDLE;
      ticks    = '0;
      errors   = 0;
    endfunction

    function void set_reg(uer_pkg::cfg_idx_t idx, logic [uer_pkg::CFG_W-1:0] val);
      case (idx)
        uer_pkg::CFG_ENABLED: enabled = val[0];
        uer_pkg::CFG_TRIGGER: trig_len = val[uer_pkg::TRIG_W-1:0];
        uer_pkg::CFG_TIMEOUT: timeout = val[uer_pkg::TMO_W-1:0];
        uer_pkg::CFG_COEF:    coef = val[uer_pkg::COEF_W-1:0];
        default:              ;
      endcase
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
      return (c == '1) ? c : c + CNT_W'(1);
    endfunction

    function logic limit_hit(logic [CNT_W-1:0] c);
      return (c >= timeout) || (c == '1);
    endfunction

    function void close(ref uer_pkg::res_t r, input uer_pkg::status_t st);
      phase = uer_pkg::PH_IDLE;
      ticks = '0;
      r.done_res = 1'b1;
      r.status = st;
    endfunction

    function void note_tick(logic start, logic echo);
      uer_pkg::res_t r;
      logic [43:0]   prod;
      logic [27:0]   dist_full;
      r = '0;
      case (phase)
        uer_pkg::PH_IDLE: begin
          if (start && !enabled) begin
            r.done_res = 1'b1;
            r.status = uer_pkg::ST_DISABLED;
          end else if (start) begin
            r.trigger_out = 1'b1;
            if (trig_len <= uer_pkg::TRIG_W'(1)) begin
              phase = uer_pkg::PH_RISE;
              ticks = '0;
            end else begin
              phase = uer_pkg::PH_TRIG;
              ticks = CNT_W'(1);
            end
          end
        end
        uer_pkg::PH_TRIG: begin
          r.trigger_out = 1'b1;
          ticks = bump(ticks);
          if (ticks >= CNT_W'(trig_len) || ticks == '1) begin
            phase = uer_pkg::PH_RISE;
            ticks = '0;
          end
        end
        uer_pkg::PH_RISE: begin
          if (echo) begin
            ticks = CNT_W'(1);
            if (limit_hit(ticks)) close(r, uer_pkg::ST_LONG);
            else phase = uer_pkg::PH_MEAS;
          end else begin
            ticks = bump(ticks);
            if (limit_hit(ticks)) close(r, uer_pkg::ST_NOECHO);
          end
        end
        default: begin
          if (!echo) begin
            prod = 44'(ticks) * 44'(coef);
            dist_full = prod[43:uer_pkg::FRAC_SH];
            r.distance_q8 = (dist_full > 28'(uer_pkg::DIST_MAX)) ?
                            uer_pkg::DIST_MAX : dist_full[uer_pkg::DIST_W-1:0];
            close(r, uer_pkg::ST_OK);
          end else begin
            ticks = bump(ticks);
            if (limit_hit(ticks)) close(r, uer_pkg::ST_LONG);
          end
        end
      endcase
      pending_results.push_back(r);
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [31:0] word);
      uer_pkg::res_t got;
      uer_pkg::res_t want;
      got = word[$bits(uer_pkg::res_t)-1:0];
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %h", word);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      field_check("trigger_out", 32'(want.trigger_out), 32'(got.trigger_out));
      field_check("done_res", 32'(want.done_res), 32'(got.done_res));
      field_check("status", 32'(want.status), 32'(got.status));
      field_check("distance_q8", 32'(want.distance_q8), 32'(got.distance_q8));
      field_check("pad", 32'(0), 32'(word[31:$bits(uer_pkg::res_t)]));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [23:0] cfg_wdata = '0;

  range_scoreboard sb;
  int unsigned     words_sent = 0;
  int unsigned     tail_mark = 32'hFFFF_FFFF;
  bit              tail = 1'b0;
  bit              tx_bursty = 1'b1;
  bit              rx_bursty = 1'b1;
  int              rx_gap = 0;
  int              rx_hold = 0;
  bit              rx_hold_done = 1'b0;
  int unsigned     idle_cycles = 0;

  always #5 clk = ~clk;

  ultrasonic_echo_ranger u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // result side: check, random stalls, one long hold
  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_result(out_tdata);
    if (!rx_hold_done && words_sent >= HOLD_AT) begin
      rx_hold_done = 1'b1;
      rx_hold = int'(HOLD_LEN);
    end
    if ($urandom_range(0, 99) == 0) rx_bursty = !rx_bursty;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else if (rx_bursty && !tail && $urandom_range(0, 5) == 0) begin
      rx_gap = int'($urandom_range(1, 15)) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ultrasonic_echo_ranger regression: fail");
        $finish;
      end
    end
  end

  task automatic send_word(input logic start, input logic echo);
    if (tx_bursty && !tail && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, echo, start};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_tick(start, echo);
    words_sent++;
    if (words_sent >= tail_mark) tail = 1'b1;
    if ($urandom_range(0, 63) == 0) tx_bursty = !tx_bursty;
  endtask

  // start requests while busy must be ignored
  function automatic logic stray_start();
    return (sb.phase != uer_pkg::PH_IDLE) && ($urandom_range(0, 1) == 1);
  endfunction

  task automatic measure(input int rise_wait, input int high_len);
    send_word(1'b1, 1'($urandom_range(0, 1)));
    while (sb.phase == uer_pkg::PH_TRIG) send_word(stray_start(), 1'($urandom_range(0, 1)));
    repeat (rise_wait) send_word(stray_start(), 1'b0);
    repeat (high_len) send_word(stray_start(), 1'b1);
    send_word(stray_start(), 1'b0);
  endtask

  task automatic settle();
    while (sb.phase != uer_pkg::PH_IDLE) send_word(1'b0, sb.phase == uer_pkg::PH_RISE);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input uer_pkg::cfg_idx_t idx,
                           input logic [uer_pkg::CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_config(input logic en, input logic [uer_pkg::TRIG_W-1:0] trig,
                            input logic [uer_pkg::TMO_W-1:0] tmo,
                            input logic [uer_pkg::COEF_W-1:0] cf);
    settle();
    write_reg(uer_pkg::CFG_ENABLED, uer_pkg::CFG_W'(en));
    write_reg(uer_pkg::CFG_TRIGGER, uer_pkg::CFG_W'(trig));
    write_reg(uer_pkg::CFG_TIMEOUT, uer_pkg::CFG_W'(tmo));
    write_reg(uer_pkg::CFG_COEF, uer_pkg::CFG_W'(cf));
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [uer_pkg::TRIG_W-1:0] trig;
    logic [uer_pkg::TMO_W-1:0]  tmo;
    logic [uer_pkg::COEF_W-1:0] cf;
    int                         lim;
    int unsigned                rand_end;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: disabled
    send_word(1'b0, 1'b0);
    send_word(1'b1, 1'b0);
    send_word(1'b1, 1'b1);
    send_word(1'b0, 1'b1);

    // zero timeout and zero coefficient
    set_config(1'b1, 10'd1, 20'd0, 24'd0);
    measure(0, 0);
    measure(0, 3);

    // zero trigger length acts as one, shortest timeout, largest coefficient
    set_config(1'b1, 10'd0, 20'd1, 24'hFFFFFF);
    measure(0, 0);
    measure(1, 0);

    set_config(1'b1, 10'd3, 20'd6, uer_pkg::COEF_RST);
    measure(2, 3);
    measure(8, 0);
    measure(0, 8);
    measure(1, 1);

    // long trigger, longest timeout, largest coefficient
    set_config(1'b1, 10'd40, 20'hFFFFF, 24'hFFFFFF);
    measure(2, 60);

    rand_end = words_sent + RAND_WORDS;
    tail_mark = rand_end - TAIL_WORDS;
    while (words_sent < rand_end) begin
      case ($urandom_range(0, 9))
        0:       trig = '0;
        1:       trig = uer_pkg::TRIG_W'($urandom_range(20, 60));
        default: trig = uer_pkg::TRIG_W'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 9))
        0:       tmo = '0;
        1:       tmo = '1;
        2:       tmo = uer_pkg::TMO_W'($urandom_range(1, 20'hFFFFF));
        default: tmo = uer_pkg::TMO_W'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 7))
        0:       cf = '0;
        1:       cf = '1;
        default: cf = uer_pkg::COEF_W'($urandom_range(0, 24'hFFFFFF));
      endcase
      set_config($urandom_range(0, 7) != 0, trig, tmo, cf);
      lim = (tmo > 28) ? 30 : int'(tmo) + 2;
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 6)) begin
            send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          end
        end else begin
          measure(int'($urandom_range(0, lim)), int'($urandom_range(0, lim)));
        end
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ultrasonic_echo_ranger regression: pass");
    end else begin
      $display("ultrasonic_echo_ranger regression: fail");
    end
    $finish;
  end

endmodule

### ultrasonic_echo_ranger.f
rtl/uer_pkg.sv
rtl/uer_dist.sv
rtl/uer_fsm.sv
rtl/ultrasonic_echo_ranger.sv
tb/testbench.sv
